// ----- rtl/wiegand26_dual_transmitter_unit_assert.svh -----
// Assertion macros for the RTL; only wdt_channel.sv includes them.
`ifndef WIEGAND26_DUAL_TRANSMITTER_UNIT_ASSERT_SVH
`define WIEGAND26_DUAL_TRANSMITTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define WDT_ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("wdt assertion failed");
`define WDT_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("wdt assertion failed");
`else
`define WDT_ASSERT_SAME(label, clk, rst, cond, prop)
`define WDT_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

// ----- rtl/wdt_pkg.sv -----
`default_nettype none

package wdt_pkg;

   localparam int FRAME_BITS = 26;
   localparam int LEFT_W     = 5;
   localparam int FC_W       = 8;
   localparam int CARD_W     = 16;
   localparam int PARITY_SPAN = 12;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_FACILITY_ADDR = 3'd0;
   localparam logic [LEFT_W-1:0]     FRAME_COUNT = LEFT_W'(FRAME_BITS);

   typedef enum logic [1:0] {
      REQ_LOAD    = 2'd0,
      REQ_TICK    = 2'd1,
      REQ_RELEASE = 2'd2,
      REQ_UNUSED  = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic load;
      logic tick;
      logic drop;
   } wdt_ctrl_type;

   typedef struct packed {
      logic d0;
      logic d1;
      logic busy;
      logic started;
   } wdt_status_type;

   function automatic logic [FRAME_BITS-1:0] build_frame(
      input logic [FC_W-1:0]   fc,
      input logic [CARD_W-1:0] card
   );
      logic hi;
      logic lo;
      hi = ^{fc, card[CARD_W-1:PARITY_SPAN]};
      lo = ~(^card[PARITY_SPAN-1:0]);
      return {hi, fc, card, lo};
   endfunction

endpackage

`default_nettype wire

// ----- rtl/wdt_req_if.sv -----
`default_nettype none

interface wdt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic        channel;
   logic [15:0] card_number;

   modport source (output valid, req_type, channel, card_number, input ready);
   modport sink (input valid, req_type, channel, card_number, output ready);
endinterface

`default_nettype wire

// ----- rtl/wdt_rsp_if.sv -----
`default_nettype none

interface wdt_rsp_if;
   logic valid;
   logic ready;
   logic panel_d0_level;
   logic panel_d1_level;
   logic reader_d0_level;
   logic reader_d1_level;
   logic pulse_started;
   logic panel_busy;
   logic reader_busy;

   modport source (output valid, panel_d0_level, panel_d1_level, reader_d0_level,
      reader_d1_level, pulse_started, panel_busy, reader_busy, input ready);
   modport sink (input valid, panel_d0_level, panel_d1_level, reader_d0_level,
      reader_d1_level, pulse_started, panel_busy, reader_busy, output ready);
endinterface

`default_nettype wire

// ----- rtl/wdt_cell.sv -----
`default_nettype none

module wdt_cell (
   input  wire logic clock,
   input  wire logic load,
   input  wire logic shift,
   input  wire logic load_bit,
   input  wire logic shift_in,
   output logic      bit_out
);
   logic bit_ff;
   logic bit_in;

   always_comb begin
      bit_in = bit_ff;
      if (load) begin
         bit_in = load_bit;
      end else if (shift) begin
         bit_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
   end

   assign bit_out = bit_ff;
endmodule

`default_nettype wire

// ----- rtl/wdt_channel.sv -----
`default_nettype none

module wdt_channel (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire wdt_pkg::wdt_ctrl_type             ctrl,
   input  wire logic [wdt_pkg::FRAME_BITS-1:0]    frame,
   output wdt_pkg::wdt_status_type                status
);
   import wdt_pkg::*;

   `include "wiegand26_dual_transmitter_unit_assert.svh"

   logic [FRAME_BITS-1:0] bits;
   logic [FRAME_BITS-1:0] chain_in;
   logic [LEFT_W-1:0]     left_ff;
   logic [LEFT_W-1:0]     left_in;
   logic                  d0_ff;
   logic                  d0_in;
   logic                  d1_ff;
   logic                  d1_in;
   logic                  busy;
   logic                  fire;
   logic                  msb;

   assign chain_in = {bits[FRAME_BITS-2:0], 1'b0};

   for (genvar i = 0; i < FRAME_BITS; i++) begin : g_cell
      wdt_cell u_cell (
         .clock    (clock),
         .load     (ctrl.load),
         .shift    (fire),
         .load_bit (frame[i]),
         .shift_in (chain_in[i]),
         .bit_out  (bits[i])
      );
   end

   assign busy = (left_ff != '0);
   assign fire = ctrl.tick & busy;
   assign msb  = bits[FRAME_BITS-1];

   always_comb begin
      left_in = left_ff;
      d0_in   = d0_ff;
      d1_in   = d1_ff;
      if (ctrl.load) begin
         left_in = FRAME_COUNT;
      end else if (fire) begin
         left_in = left_ff - LEFT_W'(1);
      end
      if (ctrl.drop) begin
         d0_in = 1'b1;
         d1_in = 1'b1;
      end else if (fire) begin
         if (msb) begin
            d1_in = 1'b0;
         end else begin
            d0_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         d0_ff   <= 1'b1;
         d1_ff   <= 1'b1;
      end else begin
         left_ff <= left_in;
         d0_ff   <= d0_in;
         d1_ff   <= d1_in;
      end
   end

   assign status.d0      = d0_in;
   assign status.d1      = d1_in;
   assign status.busy    = (left_in != '0);
   assign status.started = fire;

   `WDT_ASSERT_NEXT(a_load_count, clock, reset, ctrl.load, left_ff == FRAME_COUNT)
   `WDT_ASSERT_NEXT(a_one_pulls_d1, clock, reset, fire && msb, !d1_ff)
   `WDT_ASSERT_NEXT(a_drop_releases, clock, reset, ctrl.drop, d0_ff && d1_ff)
endmodule

`default_nettype wire

// ----- rtl/wiegand26_dual_transmitter_unit.sv -----
// Latency: a request word is accepted at one edge and its response word is
// registered at that same edge, visible in the following cycle.
// Throughput: one word per cycle if unstalled; both channels' cells shift in parallel.
// A stalled response holds in its register while the next request is taken if it frees.
// Reset: both channels idle, all four lines released high, facility code zero.
`default_nettype none

module wiegand26_dual_transmitter_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   wdt_req_if.sink                                req_chan,
   wdt_rsp_if.source                              rsp_chan,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [wdt_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [wdt_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic      [wdt_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                   pready
);
   import wdt_pkg::*;

   logic [FC_W-1:0]       fc_ff;
   logic [FC_W-1:0]       fc_in;
   logic                  valid_ff;
   logic                  valid_in;
   wdt_status_type        panel_ff;
   wdt_status_type        reader_ff;
   wdt_status_type        panel_st;
   wdt_status_type        reader_st;
   wdt_ctrl_type          panel_ctrl;
   wdt_ctrl_type          reader_ctrl;
   logic [FRAME_BITS-1:0] frame;
   logic                  accept;
   logic                  is_load;
   logic                  is_tick;
   logic                  is_drop;

   assign pready = 1'b1;
   assign prdata = (paddr == CSR_FACILITY_ADDR) ? CSR_DATA_W'(fc_ff) : '0;
   assign fc_in  = (psel && penable && pwrite && paddr == CSR_FACILITY_ADDR)
                   ? pwdata[FC_W-1:0] : fc_ff;

   assign req_chan.ready = !valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign is_load = accept && (req_chan.req_type == REQ_LOAD);
   assign is_tick = accept && (req_chan.req_type == REQ_TICK);
   assign is_drop = accept && (req_chan.req_type == REQ_RELEASE);

   assign frame = build_frame(fc_ff, req_chan.card_number);

   assign panel_ctrl  = '{load: is_load && req_chan.channel, tick: is_tick, drop: is_drop};
   assign reader_ctrl = '{load: is_load && !req_chan.channel, tick: is_tick, drop: is_drop};

   wdt_channel u_panel (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (panel_ctrl),
      .frame  (frame),
      .status (panel_st)
   );

   wdt_channel u_reader (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (reader_ctrl),
      .frame  (frame),
      .status (reader_st)
   );

   assign valid_in = accept || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         fc_ff    <= '0;
      end else begin
         valid_ff <= valid_in;
         fc_ff    <= fc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         panel_ff  <= panel_st;
         reader_ff <= reader_st;
      end
   end

   assign rsp_chan.valid           = valid_ff;
   assign rsp_chan.panel_d0_level  = panel_ff.d0;
   assign rsp_chan.panel_d1_level  = panel_ff.d1;
   assign rsp_chan.reader_d0_level = reader_ff.d0;
   assign rsp_chan.reader_d1_level = reader_ff.d1;
   assign rsp_chan.pulse_started   = panel_ff.started || reader_ff.started;
   assign rsp_chan.panel_busy      = panel_ff.busy;
   assign rsp_chan.reader_busy     = reader_ff.busy;
endmodule

`default_nettype wire
